### design/jcpf_pkg.sv
// shared types and constants for the jaus command packet filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jcpf_pkg;

   localparam int COUNT_BITS = 9;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] FRAME_FIXED = COUNT_BITS'(24);

   // frame offsets
   localparam logic [COUNT_BITS-1:0] POS_MAGIC_END = COUNT_BITS'(8);
   localparam logic [COUNT_BITS-1:0] POS_CMD_LO    = COUNT_BITS'(10);
   localparam logic [COUNT_BITS-1:0] POS_CMD_HI    = COUNT_BITS'(11);
   localparam logic [COUNT_BITS-1:0] POS_DEST_INST = COUNT_BITS'(12);
   localparam logic [COUNT_BITS-1:0] POS_DEST_COMP = COUNT_BITS'(13);
   localparam logic [COUNT_BITS-1:0] POS_DEST_NODE = COUNT_BITS'(14);
   localparam logic [COUNT_BITS-1:0] POS_SRC_INST  = COUNT_BITS'(16);
   localparam logic [COUNT_BITS-1:0] POS_SRC_COMP  = COUNT_BITS'(17);
   localparam logic [COUNT_BITS-1:0] POS_SRC_NODE  = COUNT_BITS'(18);
   localparam logic [COUNT_BITS-1:0] POS_SRC_SUBS  = COUNT_BITS'(19);
   localparam logic [COUNT_BITS-1:0] POS_LENGTH    = COUNT_BITS'(20);
   localparam logic [COUNT_BITS-1:0] POS_PAYLOAD0  = COUNT_BITS'(24);
   localparam logic [COUNT_BITS-1:0] POS_PAYLOAD1  = COUNT_BITS'(25);
   localparam logic [COUNT_BITS-1:0] POS_PAYLOAD2  = COUNT_BITS'(26);

   localparam logic [15:0] CMD_HALT    = 16'h0003;
   localparam logic [15:0] CMD_GO      = 16'h0004;
   localparam logic [15:0] CMD_DEVICES = 16'h0406;

   // "JAUS01.0"
   localparam logic [7:0] MAGIC [8] = '{8'h4A, 8'h41, 8'h55, 8'h53,
                                        8'h30, 8'h31, 8'h2E, 8'h30};

   // configuration register indexes
   localparam int NUM_REGS = 7;
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEST_INSTANCE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEST_COMPONENT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEST_NODE        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_INSTANCE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_COMPONENT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_NODE      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_SUBSYSTEM = 3'd6;

   localparam logic [7:0] RESET_IDS [NUM_REGS] = '{8'd1, 8'd33, 8'd1, 8'd1,
                                                  8'd40, 8'd1, 8'd1};

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_COUNT_BITS = 2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_HALT,
      OP_GO,
      OP_WARN
   } flag_op_type;

   // one classified packet, front to back
   typedef struct packed {
      logic        accepted;
      logic [15:0] command_code;
      flag_op_type op;
      logic        warn_value;
   } item_type;

endpackage

`default_nettype wire

### design/jcpf_front.sv
// front end: byte counting, header and id checks, packet classification
// depends on jcpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module jcpf_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               byte_take,
   input  wire logic [7:0]                         data_byte,
   input  wire logic                               end_of_packet,
   input  wire logic                               csr_write,
   input  wire logic [jcpf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [7:0]                         csr_wdata,
   output logic                                    push,
   output jcpf_pkg::item_type                      push_item
);

   logic [7:0] id_ff [jcpf_pkg::NUM_REGS];

   logic [jcpf_pkg::COUNT_BITS-1:0] pos_ff;
   logic [jcpf_pkg::COUNT_BITS-1:0] pos_in;
   logic                            hdr_ff, hdr_in;
   logic [7:0]                      len_ff, len_in;
   logic [15:0]                     cmd_ff, cmd_in;
   logic [7:0]                      ph_ff [3];
   logic [7:0]                      ph_in [3];
   logic                            want_valid;
   logic [7:0]                      want;
   logic                            ok;
   logic [jcpf_pkg::COUNT_BITS-1:0] len_total;

   // expected byte for the checked offsets
   always_comb begin
      want_valid = 1'b1;
      want       = 8'd0;
      if (pos_ff < jcpf_pkg::POS_MAGIC_END) begin
         want = jcpf_pkg::MAGIC[pos_ff[2:0]];
      end else if (pos_ff == jcpf_pkg::POS_DEST_INST) begin
         want = id_ff[jcpf_pkg::REG_DEST_INSTANCE];
      end else if (pos_ff == jcpf_pkg::POS_DEST_COMP) begin
         want = id_ff[jcpf_pkg::REG_DEST_COMPONENT];
      end else if (pos_ff == jcpf_pkg::POS_DEST_NODE) begin
         want = id_ff[jcpf_pkg::REG_DEST_NODE];
      end else if (pos_ff == jcpf_pkg::POS_SRC_INST) begin
         want = id_ff[jcpf_pkg::REG_SOURCE_INSTANCE];
      end else if (pos_ff == jcpf_pkg::POS_SRC_COMP) begin
         want = id_ff[jcpf_pkg::REG_SOURCE_COMPONENT];
      end else if (pos_ff == jcpf_pkg::POS_SRC_NODE) begin
         want = id_ff[jcpf_pkg::REG_SOURCE_NODE];
      end else if (pos_ff == jcpf_pkg::POS_SRC_SUBS) begin
         want = id_ff[jcpf_pkg::REG_SOURCE_SUBSYSTEM];
      end else begin
         want_valid = 1'b0;
      end
   end

   always_comb begin
      hdr_in = hdr_ff && !(want_valid && (data_byte != want));
      len_in = (pos_ff == jcpf_pkg::POS_LENGTH) ? data_byte : len_ff;
      cmd_in = cmd_ff;
      if (pos_ff == jcpf_pkg::POS_CMD_LO) cmd_in[7:0] = data_byte;
      if (pos_ff == jcpf_pkg::POS_CMD_HI) cmd_in[15:8] = data_byte;
      ph_in[0] = (pos_ff == jcpf_pkg::POS_PAYLOAD0) ? data_byte : ph_ff[0];
      ph_in[1] = (pos_ff == jcpf_pkg::POS_PAYLOAD1) ? data_byte : ph_ff[1];
      ph_in[2] = (pos_ff == jcpf_pkg::POS_PAYLOAD2) ? data_byte : ph_ff[2];
      // count saturates so an over-long packet can never match its length
      pos_in = (pos_ff != jcpf_pkg::COUNT_MAX) ?
               pos_ff + jcpf_pkg::COUNT_BITS'(1) : pos_ff;
   end

   assign len_total = jcpf_pkg::FRAME_FIXED + jcpf_pkg::COUNT_BITS'(len_in);

   always_comb begin
      ok = hdr_in && (pos_in != jcpf_pkg::COUNT_MAX) &&
           (pos_in >= jcpf_pkg::FRAME_FIXED) && (pos_in == len_total);
      push_item.accepted     = ok;
      push_item.command_code = ok ? cmd_in : 16'd0;
      push_item.warn_value   = ph_in[0][0] ? ph_in[2][1] : ph_in[1][1];
      push_item.op           = jcpf_pkg::OP_NONE;
      if (ok) begin
         if (cmd_in == jcpf_pkg::CMD_HALT) begin
            push_item.op = jcpf_pkg::OP_HALT;
         end else if (cmd_in == jcpf_pkg::CMD_GO) begin
            push_item.op = jcpf_pkg::OP_GO;
         end else if (cmd_in == jcpf_pkg::CMD_DEVICES && len_in != 8'd0 && ph_in[0][1]) begin
            push_item.op = jcpf_pkg::OP_WARN;
         end
      end
   end

   assign push = byte_take && end_of_packet;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         hdr_ff   <= 1'b1;
         len_ff   <= 8'd0;
         cmd_ff   <= 16'd0;
         ph_ff[0] <= 8'd0;
         ph_ff[1] <= 8'd0;
         ph_ff[2] <= 8'd0;
      end else if (byte_take) begin
         if (end_of_packet) begin
            pos_ff   <= '0;
            hdr_ff   <= 1'b1;
            len_ff   <= 8'd0;
            cmd_ff   <= 16'd0;
            ph_ff[0] <= 8'd0;
            ph_ff[1] <= 8'd0;
            ph_ff[2] <= 8'd0;
         end else begin
            pos_ff   <= pos_in;
            hdr_ff   <= hdr_in;
            len_ff   <= len_in;
            cmd_ff   <= cmd_in;
            ph_ff[0] <= ph_in[0];
            ph_ff[1] <= ph_in[1];
            ph_ff[2] <= ph_in[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < jcpf_pkg::NUM_REGS; i++) id_ff[i] <= jcpf_pkg::RESET_IDS[i];
      end else if (csr_write) begin
         unique case (csr_index)
            jcpf_pkg::REG_DEST_INSTANCE:    id_ff[jcpf_pkg::REG_DEST_INSTANCE] <= csr_wdata;
            jcpf_pkg::REG_DEST_COMPONENT:   id_ff[jcpf_pkg::REG_DEST_COMPONENT] <= csr_wdata;
            jcpf_pkg::REG_DEST_NODE:        id_ff[jcpf_pkg::REG_DEST_NODE] <= csr_wdata;
            jcpf_pkg::REG_SOURCE_INSTANCE:  id_ff[jcpf_pkg::REG_SOURCE_INSTANCE] <= csr_wdata;
            jcpf_pkg::REG_SOURCE_COMPONENT: id_ff[jcpf_pkg::REG_SOURCE_COMPONENT] <= csr_wdata;
            jcpf_pkg::REG_SOURCE_NODE:      id_ff[jcpf_pkg::REG_SOURCE_NODE] <= csr_wdata;
            jcpf_pkg::REG_SOURCE_SUBSYSTEM: id_ff[jcpf_pkg::REG_SOURCE_SUBSYSTEM] <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### design/jcpf_queue.sv
// short queue of classified packets between front and back ends
// depends on jcpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module jcpf_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire jcpf_pkg::item_type push_item,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output jcpf_pkg::item_type      head_item
);

   jcpf_pkg::item_type entry_ff [jcpf_pkg::QUEUE_DEPTH];
   logic [jcpf_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [jcpf_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == jcpf_pkg::QUEUE_COUNT_BITS'(jcpf_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + jcpf_pkg::QUEUE_COUNT_BITS'(1);
      if (pop && !push) count_in = count_ff - jcpf_pkg::QUEUE_COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + jcpf_pkg::QUEUE_PTR_BITS'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + jcpf_pkg::QUEUE_PTR_BITS'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= jcpf_pkg::QUEUE_COUNT_BITS'(jcpf_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + jcpf_pkg::QUEUE_COUNT_BITS'(1)))
      else $error("queue count did not follow a write");
`endif

endmodule

`default_nettype wire

### design/jcpf_back.sv
// back end: applies flag updates and holds the result register
// depends on jcpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module jcpf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_ready,
   input  wire jcpf_pkg::item_type head_item,
   output logic                    pop,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output logic                    rsp_packet_accepted,
   output logic [15:0]             rsp_command_code,
   output logic                    rsp_mobility_enabled,
   output logic                    rsp_warning_active
);

   logic        mob_ff, mob_in;
   logic        warn_ff, warn_in;
   logic        valid_ff;
   logic        acc_ff;
   logic [15:0] cmd_ff;

   assign pop = item_ready && (!valid_ff || !rsp_stall);

   always_comb begin
      mob_in  = mob_ff;
      warn_in = warn_ff;
      unique case (head_item.op)
         jcpf_pkg::OP_HALT: mob_in  = 1'b0;
         jcpf_pkg::OP_GO:   mob_in  = 1'b1;
         jcpf_pkg::OP_WARN: warn_in = head_item.warn_value;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mob_ff   <= 1'b0;
         warn_ff  <= 1'b0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            mob_ff   <= mob_in;
            warn_ff  <= warn_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         acc_ff <= head_item.accepted;
         cmd_ff <= head_item.command_code;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_packet_accepted  = acc_ff;
   assign rsp_command_code     = cmd_ff;
   assign rsp_mobility_enabled = mob_ff;
   assign rsp_warning_active   = warn_ff;

endmodule

`default_nettype wire

### design/jaus_command_packet_filter_unit.sv
// result path: the final byte of a packet is written into the queue, then popped into the back end's
// result register, which an output stall can hold back, and shown on rsp_valid from there
// throughput: one byte per cycle, a packet of any length every byte; the front end
// stalls only when both queue slots hold results the output side has not taken
// reset (synchronous): id registers return to their defaults, flags clear,
// the byte counter and the queue empty; no clearing pass is needed
// depends on jcpf_pkg, jcpf_front, jcpf_queue, jcpf_back
`timescale 1ns / 1ps
`default_nettype none

module jaus_command_packet_filter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                req_end_of_packet,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_packet_accepted,
   output logic [15:0]                              rsp_command_code,
   output logic                                     rsp_mobility_enabled,
   output logic                                     rsp_warning_active,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [jcpf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [7:0]                          csr_wdata
);

   logic               byte_take;
   logic               push, pop, full, not_empty;
   jcpf_pkg::item_type push_item, head_item;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign byte_take = req_valid && !req_stall;

   jcpf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .byte_take     (byte_take),
      .data_byte     (req_data_byte),
      .end_of_packet (req_end_of_packet),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .push          (push),
      .push_item     (push_item)
   );

   jcpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   jcpf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .item_ready           (not_empty),
      .head_item            (head_item),
      .pop                  (pop),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_packet_accepted  (rsp_packet_accepted),
      .rsp_command_code     (rsp_command_code),
      .rsp_mobility_enabled (rsp_mobility_enabled),
      .rsp_warning_active   (rsp_warning_active)
   );

endmodule

`default_nettype wire
